[rtl/lsct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsct_pkg
// Shared types, constants and the ring cosine/sine table of the tessellator.
// ----------------------------------------------------------------------------
package lsct_pkg;

  localparam int COORD_W    = 32;
  localparam int WIDTH_W    = 31;
  localparam int RING_STEPS = 12;
  localparam int TRI_COUNT  = 4 * RING_STEPS;
  localparam int TRI_IDX_W  = $clog2(TRI_COUNT);
  localparam int STEP_W     = $clog2(RING_STEPS);

  // Triangle kinds within one ring step, in emission order.
  localparam logic [1:0] TRI_SIDE_A    = 2'd0;
  localparam logic [1:0] TRI_SIDE_B    = 2'd1;
  localparam logic [1:0] TRI_START_CAP = 2'd2;
  localparam logic [1:0] TRI_END_CAP   = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic [WIDTH_W-1:0]        line_width;
  } seg_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
    logic                      last_triangle;
  } tri_out_t;

  // Segment with the x and z parts of its unit direction, handed from the front end to the back end.
  typedef struct packed {
    seg_in_t     seg;
    logic [30:0] nx_mag;
    logic        nx_neg;
    logic [30:0] nz_mag;
    logic        nz_neg;
  } dir_seg_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } trig_t;

  // Reduced angles of one third and two thirds of a quadrant, Q2.30.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned X4 = (HALF_PI_Q30 * 64'd4 + 64'd6) / 64'd12;
  localparam longint unsigned X8 = (HALF_PI_Q30 * 64'd8 + 64'd6) / 64'd12;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  // Truncated Taylor terms for the first reduced angle.
  localparam longint unsigned A0  = ONE_Q30;
  localparam longint unsigned A1  = ((A0  * X4) >> 30) / 64'd1;
  localparam longint unsigned A2  = ((A1  * X4) >> 30) / 64'd2;
  localparam longint unsigned A3  = ((A2  * X4) >> 30) / 64'd3;
  localparam longint unsigned A4  = ((A3  * X4) >> 30) / 64'd4;
  localparam longint unsigned A5  = ((A4  * X4) >> 30) / 64'd5;
  localparam longint unsigned A6  = ((A5  * X4) >> 30) / 64'd6;
  localparam longint unsigned A7  = ((A6  * X4) >> 30) / 64'd7;
  localparam longint unsigned A8  = ((A7  * X4) >> 30) / 64'd8;
  localparam longint unsigned A9  = ((A8  * X4) >> 30) / 64'd9;
  localparam longint unsigned A10 = ((A9  * X4) >> 30) / 64'd10;
  localparam longint unsigned A11 = ((A10 * X4) >> 30) / 64'd11;
  localparam longint unsigned A12 = ((A11 * X4) >> 30) / 64'd12;
  localparam longint unsigned A13 = ((A12 * X4) >> 30) / 64'd13;
  localparam longint unsigned A14 = ((A13 * X4) >> 30) / 64'd14;
  localparam longint unsigned A15 = ((A14 * X4) >> 30) / 64'd15;
  localparam longint unsigned A16 = ((A15 * X4) >> 30) / 64'd16;
  localparam longint unsigned A17 = ((A16 * X4) >> 30) / 64'd17;

  // Truncated Taylor terms for the second reduced angle.
  localparam longint unsigned B0  = ONE_Q30;
  localparam longint unsigned B1  = ((B0  * X8) >> 30) / 64'd1;
  localparam longint unsigned B2  = ((B1  * X8) >> 30) / 64'd2;
  localparam longint unsigned B3  = ((B2  * X8) >> 30) / 64'd3;
  localparam longint unsigned B4  = ((B3  * X8) >> 30) / 64'd4;
  localparam longint unsigned B5  = ((B4  * X8) >> 30) / 64'd5;
  localparam longint unsigned B6  = ((B5  * X8) >> 30) / 64'd6;
  localparam longint unsigned B7  = ((B6  * X8) >> 30) / 64'd7;
  localparam longint unsigned B8  = ((B7  * X8) >> 30) / 64'd8;
  localparam longint unsigned B9  = ((B8  * X8) >> 30) / 64'd9;
  localparam longint unsigned B10 = ((B9  * X8) >> 30) / 64'd10;
  localparam longint unsigned B11 = ((B10 * X8) >> 30) / 64'd11;
  localparam longint unsigned B12 = ((B11 * X8) >> 30) / 64'd12;
  localparam longint unsigned B13 = ((B12 * X8) >> 30) / 64'd13;
  localparam longint unsigned B14 = ((B13 * X8) >> 30) / 64'd14;
  localparam longint unsigned B15 = ((B14 * X8) >> 30) / 64'd15;
  localparam longint unsigned B16 = ((B15 * X8) >> 30) / 64'd16;
  localparam longint unsigned B17 = ((B16 * X8) >> 30) / 64'd17;

  localparam longint C4_RAW = longint'(A0) - longint'(A2) + longint'(A4) - longint'(A6)
                            + longint'(A8) - longint'(A10) + longint'(A12)
                            - longint'(A14) + longint'(A16);
  localparam longint S4_RAW = longint'(A1) - longint'(A3) + longint'(A5) - longint'(A7)
                            + longint'(A9) - longint'(A11) + longint'(A13)
                            - longint'(A15) + longint'(A17);
  localparam longint C8_RAW = longint'(B0) - longint'(B2) + longint'(B4) - longint'(B6)
                            + longint'(B8) - longint'(B10) + longint'(B12)
                            - longint'(B14) + longint'(B16);
  localparam longint S8_RAW = longint'(B1) - longint'(B3) + longint'(B5) - longint'(B7)
                            + longint'(B9) - longint'(B11) + longint'(B13)
                            - longint'(B15) + longint'(B17);

  localparam longint ONE_S = longint'(ONE_Q30);

  localparam logic signed [31:0] ONE = 32'sd1073741824;
  localparam logic signed [31:0] C4 = 32'(C4_RAW < 0 ? 0 : (C4_RAW > ONE_S ? ONE_S : C4_RAW));
  localparam logic signed [31:0] S4 = 32'(S4_RAW < 0 ? 0 : (S4_RAW > ONE_S ? ONE_S : S4_RAW));
  localparam logic signed [31:0] C8 = 32'(C8_RAW < 0 ? 0 : (C8_RAW > ONE_S ? ONE_S : C8_RAW));
  localparam logic signed [31:0] S8 = 32'(S8_RAW < 0 ? 0 : (S8_RAW > ONE_S ? ONE_S : S8_RAW));

  // Cosine and sine of ring step k, Q2.30.
  function automatic trig_t ring_trig(input logic [STEP_W-1:0] k);
    trig_t t;
    t.c = ONE;
    t.s = 32'sd0;
    case (k)
      4'd1:    begin t.c = C4;   t.s = S4;   end
      4'd2:    begin t.c = C8;   t.s = S8;   end
      4'd3:    begin t.c = 32'sd0; t.s = ONE; end
      4'd4:    begin t.c = -S4;  t.s = C4;   end
      4'd5:    begin t.c = -S8;  t.s = C8;   end
      4'd6:    begin t.c = -ONE; t.s = 32'sd0; end
      4'd7:    begin t.c = -C4;  t.s = -S4;  end
      4'd8:    begin t.c = -C8;  t.s = -S8;  end
      4'd9:    begin t.c = 32'sd0; t.s = -ONE; end
      4'd10:   begin t.c = S4;   t.s = -C4;  end
      4'd11:   begin t.c = S8;   t.s = -C8;  end
      default: begin t.c = ONE;  t.s = 32'sd0; end
    endcase
    return t;
  endfunction

endpackage

[rtl/lsct_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsct_front
// Takes segments and finds the unit direction with an iterative square root
// and two iterative dividers, two bits a cycle each.
// ----------------------------------------------------------------------------
module lsct_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  lsct_pkg::seg_in_t    segment,
  output logic                 push,
  output lsct_pkg::dir_seg_t   push_data,
  input  logic                 full
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NORM = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_PUSH = 3'd6;

  logic [2:0] state;
  logic       hold_valid;
  lsct_pkg::seg_in_t hold;
  lsct_pkg::seg_in_t work;
  logic [32:0] ax, ay, az;
  logic        sx, sz;
  logic [61:0] sqx, sqy, sqz;
  logic [63:0] root_src;
  logic [34:0] root_rem;
  logic [31:0] root;
  logic [31:0] rem_x, rem_z, sh_x, sh_z, q_x, q_z;
  logic [3:0]  cnt;

  logic signed [32:0] dx, dz, dy;
  logic [32:0] m, mxy;
  logic [63:0] rt_src;
  logic [34:0] rt_rem, rt_trial;
  logic [31:0] rt_root;
  logic [32:0] dvx_rem, dvz_rem;
  logic [31:0] dvx_sh, dvz_sh, dvx_q, dvz_q;

  assign busy = hold_valid;

  always_comb begin
    dx = {work.end_x[31], work.end_x} - {work.start_x[31], work.start_x};
    dy = {work.end_y[31], work.end_y} - {work.start_y[31], work.start_y};
    dz = {work.end_z[31], work.end_z} - {work.start_z[31], work.start_z};
    mxy = (ax > ay) ? ax : ay;
    m = (mxy > az) ? mxy : az;
  end

  // Two steps of the digit-by-digit square root.
  always_comb begin
    rt_src = root_src;
    rt_rem = root_rem;
    rt_root = root;
    rt_trial = '0;
    for (int i = 0; i < 2; i++) begin
      rt_rem = {rt_rem[32:0], rt_src[63:62]};
      rt_src = {rt_src[61:0], 2'b00};
      rt_trial = {1'b0, rt_root, 2'b01};
      if (rt_rem >= rt_trial) begin
        rt_rem = rt_rem - rt_trial;
        rt_root = {rt_root[30:0], 1'b1};
      end else begin
        rt_root = {rt_root[30:0], 1'b0};
      end
    end
  end

  // Two steps of each restoring divider; the divisor is the length.
  always_comb begin
    dvx_sh = sh_x;
    dvz_sh = sh_z;
    dvx_q = q_x;
    dvz_q = q_z;
    dvx_rem = {1'b0, rem_x};
    dvz_rem = {1'b0, rem_z};
    for (int i = 0; i < 2; i++) begin
      dvx_rem = {dvx_rem[31:0], dvx_sh[31]};
      dvz_rem = {dvz_rem[31:0], dvz_sh[31]};
      dvx_sh = {dvx_sh[30:0], 1'b0};
      dvz_sh = {dvz_sh[30:0], 1'b0};
      if (dvx_rem >= {1'b0, root}) begin
        dvx_rem = dvx_rem - {1'b0, root};
        dvx_q = {dvx_q[30:0], 1'b1};
      end else begin
        dvx_q = {dvx_q[30:0], 1'b0};
      end
      if (dvz_rem >= {1'b0, root}) begin
        dvz_rem = dvz_rem - {1'b0, root};
        dvz_q = {dvz_q[30:0], 1'b1};
      end else begin
        dvz_q = {dvz_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hold_valid <= 1'b0;
      cnt <= 4'd0;
    end else begin
      if (start && !hold_valid) begin
        hold_valid <= 1'b1;
        hold <= segment;
      end
      unique case (state)
        ST_IDLE: begin
          if (hold_valid) begin
            work <= hold;
            hold_valid <= 1'b0;
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (cnt == 4'd0) begin
            // First cycle here: form the magnitudes of the difference.
            ax <= dx[32] ? 33'(-dx) : 33'(dx);
            ay <= dy[32] ? 33'(-dy) : 33'(dy);
            az <= dz[32] ? 33'(-dz) : 33'(dz);
            sx <= dx[32];
            sz <= dz[32];
            cnt <= 4'd1;
          end else if (m == 33'd0) begin
            q_x <= '0;
            q_z <= '0;
            state <= ST_PUSH;
          end else if (m[32:31] != 2'b00) begin
            ax <= ax >> 1;
            ay <= ay >> 1;
            az <= az >> 1;
          end else if (m[30:23] == 8'd0) begin
            ax <= ax << 8;
            ay <= ay << 8;
            az <= az << 8;
          end else if (!m[30]) begin
            ax <= ax << 1;
            ay <= ay << 1;
            az <= az << 1;
          end else begin
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          sqx <= ax[30:0] * ax[30:0];
          sqy <= ay[30:0] * ay[30:0];
          sqz <= az[30:0] * az[30:0];
          state <= ST_SUM;
        end
        ST_SUM: begin
          root_src <= {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
          root_rem <= '0;
          root <= '0;
          cnt <= 4'd0;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          root_src <= rt_src;
          root_rem <= rt_rem;
          root <= rt_root;
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            rem_x <= {3'b000, ax[30:2]};
            rem_z <= {3'b000, az[30:2]};
            sh_x <= {ax[1:0], 30'd0};
            sh_z <= {az[1:0], 30'd0};
            q_x <= '0;
            q_z <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_x <= dvx_rem[31:0];
          rem_z <= dvz_rem[31:0];
          sh_x <= dvx_sh;
          sh_z <= dvz_sh;
          q_x <= dvx_q;
          q_z <= dvz_q;
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!full) begin
            cnt <= 4'd0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign push = (state == ST_PUSH) && !full;

  always_comb begin
    push_data.seg = work;
    push_data.nx_mag = q_x[30:0];
    push_data.nx_neg = sx;
    push_data.nz_mag = q_z[30:0];
    push_data.nz_neg = sz;
  end

endmodule

[rtl/lsct_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsct_queue
// Two-entry queue of normalized segments between the front and back ends.
// ----------------------------------------------------------------------------
module lsct_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lsct_pkg::dir_seg_t push_data,
  output logic               full,
  input  logic               pop,
  output lsct_pkg::dir_seg_t head,
  output logic               empty
);

  lsct_pkg::dir_seg_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

[rtl/lsct_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsct_back
// Walks the ring of one segment and emits one triangle per cycle through a
// three-stage offset and vertex pipeline.
// ----------------------------------------------------------------------------
module lsct_back (
  input  logic               clk,
  input  logic               rst,
  input  lsct_pkg::dir_seg_t head,
  input  logic               empty,
  output logic               pop,
  output logic               valid,
  output lsct_pkg::tri_out_t triangle
);

  localparam logic [lsct_pkg::TRI_IDX_W-1:0] LAST_IDX =
    lsct_pkg::TRI_IDX_W'(lsct_pkg::TRI_COUNT - 1);
  localparam logic [lsct_pkg::STEP_W-1:0] LAST_STEP =
    lsct_pkg::STEP_W'(lsct_pkg::RING_STEPS - 1);

  typedef struct packed {
    logic [30:0] xm;
    logic        xneg;
    logic [30:0] ym;
    logic        yneg;
    logic [30:0] zm;
    logic        zneg;
  } part_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  // Stage 0: current segment and triangle index.
  lsct_pkg::dir_seg_t cur;
  logic                              active;
  logic [lsct_pkg::TRI_IDX_W-1:0]    idx;

  // Stage 1 and 2 registers.
  logic        v1, v2;
  logic [1:0]  kind1, kind2;
  logic        last1, last2;
  lsct_pkg::seg_in_t seg1, seg2;
  part_t       p1a, p1b;
  vec_t        o2a, o2b;

  logic [lsct_pkg::STEP_W-1:0] k, k_next;
  lsct_pkg::trig_t ta, tb;
  vec_t s_o1, s_o2, e_o1, e_o2, s_pt, e_pt;

  assign pop = (!active || idx == LAST_IDX) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx <= '0;
    end else if (pop) begin
      active <= 1'b1;
      idx <= '0;
      cur <= head;
    end else if (active) begin
      if (idx == LAST_IDX) active <= 1'b0;
      else idx <= idx + 1'b1;
    end
  end

  function automatic logic [30:0] mag31(input logic signed [31:0] v);
    logic signed [31:0] n;
    n = -v;
    return v[31] ? n[30:0] : v[30:0];
  endfunction

  function automatic logic [30:0] rnd30(input logic [61:0] p);
    logic [62:0] r;
    r = {1'b0, p} + (63'd1 << 29);
    return r[60:30];
  endfunction

  function automatic logic [30:0] rnd31(input logic [61:0] p);
    logic [62:0] r;
    r = {1'b0, p} + (63'd1 << 30);
    return r[61:31];
  endfunction

  function automatic part_t stage1(input lsct_pkg::dir_seg_t d, input lsct_pkg::trig_t t);
    part_t p;
    logic [30:0] sm;
    sm = mag31(t.s);
    // The x offset is the negated z-direction term.
    p.xm = rnd30(d.nz_mag * sm);
    p.xneg = !(d.nz_neg ^ t.s[31]);
    p.zm = rnd30(d.nx_mag * sm);
    p.zneg = d.nx_neg ^ t.s[31];
    p.ym = mag31(t.c);
    p.yneg = t.c[31];
    return p;
  endfunction

  function automatic logic signed [31:0] scale(input logic [30:0] m, input logic neg,
                                               input logic [30:0] w);
    logic [30:0] r;
    r = rnd31(m * w);
    return neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  function automatic vec_t stage2(input part_t p, input logic [30:0] w);
    vec_t o;
    o.x = scale(p.xm, p.xneg, w);
    o.y = scale(p.ym, p.yneg, w);
    o.z = scale(p.zm, p.zneg, w);
    return o;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return s[31:0];
  endfunction

  function automatic vec_t vadd(input vec_t a, input vec_t b);
    vec_t r;
    r.x = sat_add(a.x, b.x);
    r.y = sat_add(a.y, b.y);
    r.z = sat_add(a.z, b.z);
    return r;
  endfunction

  always_comb begin
    k = idx[lsct_pkg::TRI_IDX_W-1:2];
    k_next = (k == LAST_STEP) ? '0 : k + 1'b1;
    ta = lsct_pkg::ring_trig(k);
    tb = lsct_pkg::ring_trig(k_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      valid <= 1'b0;
    end else begin
      v1 <= active;
      v2 <= v1;
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    kind1 <= idx[1:0];
    last1 <= (idx == LAST_IDX);
    seg1 <= cur.seg;
    p1a <= stage1(cur, ta);
    p1b <= stage1(cur, tb);
    kind2 <= kind1;
    last2 <= last1;
    seg2 <= seg1;
    o2a <= stage2(p1a, seg1.line_width);
    o2b <= stage2(p1b, seg1.line_width);
  end

  always_comb begin
    s_pt = '{x: seg2.start_x, y: seg2.start_y, z: seg2.start_z};
    e_pt = '{x: seg2.end_x, y: seg2.end_y, z: seg2.end_z};
    s_o1 = vadd(s_pt, o2a);
    s_o2 = vadd(s_pt, o2b);
    e_o1 = vadd(e_pt, o2a);
    e_o2 = vadd(e_pt, o2b);
  end

  always_ff @(posedge clk) begin
    triangle.last_triangle <= last2 && (kind2 == lsct_pkg::TRI_END_CAP);
    case (kind2)
      lsct_pkg::TRI_SIDE_A: begin
        {triangle.v0_x, triangle.v0_y, triangle.v0_z} <= s_o1;
        {triangle.v1_x, triangle.v1_y, triangle.v1_z} <= s_o2;
        {triangle.v2_x, triangle.v2_y, triangle.v2_z} <= e_o1;
      end
      lsct_pkg::TRI_SIDE_B: begin
        {triangle.v0_x, triangle.v0_y, triangle.v0_z} <= s_o2;
        {triangle.v1_x, triangle.v1_y, triangle.v1_z} <= e_o2;
        {triangle.v2_x, triangle.v2_y, triangle.v2_z} <= e_o1;
      end
      lsct_pkg::TRI_START_CAP: begin
        {triangle.v0_x, triangle.v0_y, triangle.v0_z} <= s_pt;
        {triangle.v1_x, triangle.v1_y, triangle.v1_z} <= s_o1;
        {triangle.v2_x, triangle.v2_y, triangle.v2_z} <= s_o2;
      end
      default: begin
        {triangle.v0_x, triangle.v0_y, triangle.v0_z} <= e_pt;
        {triangle.v1_x, triangle.v1_y, triangle.v1_z} <= e_o2;
        {triangle.v2_x, triangle.v2_y, triangle.v2_z} <= e_o1;
      end
    endcase
  end

endmodule

[rtl/line_segment_cylinder_tessellator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_segment_cylinder_tessellator
// Turns a line segment into a 12-sided tube of 48 triangles.
//
// channel   | handshake          | payload
// segment   | start / busy       | seg_in_t: start, end, line_width
// triangle  | valid (no stall)   | tri_out_t: three vertices, last_triangle
//
// Each segment yields 48 triangles, one per cycle; this emitter sets the
// sustained rate. The front end's time per segment depends on how far the
// difference must be shifted (a zero-length one skips the root and divide),
// and it runs ahead of the emitter.
// Reset clears all control state; no memory is cleared. The receiver cannot
// stall; busy only holds while the one-segment input register is occupied.
// ----------------------------------------------------------------------------
module line_segment_cylinder_tessellator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lsct_pkg::seg_in_t  segment,
  output logic               valid,
  output lsct_pkg::tri_out_t triangle
);

  logic               push, full, pop, empty;
  lsct_pkg::dir_seg_t push_data, head;

  lsct_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .segment(segment),
    .push(push), .push_data(push_data), .full(full)
  );

  lsct_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .head(head), .empty(empty)
  );

  lsct_back u_back (
    .clk(clk), .rst(rst), .head(head), .empty(empty), .pop(pop),
    .valid(valid), .triangle(triangle)
  );

endmodule

[tb/tb_line_segment_cylinder_tessellator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_segment_cylinder_tessellator
// Self-checking bench for the segment to tube tessellator. Segments are
// driven in random bursts. Each accepted segment is expanded into its 48
// expected triangles by a fixed-point predictor. Every triangle strobe is
// compared as a whole against the oldest expected triangle.
// ----------------------------------------------------------------------------
module tb_line_segment_cylinder_tessellator;

  localparam int TIMEOUT_CYCLES = 400000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  lsct_pkg::seg_in_t  segment;
  logic               valid;
  lsct_pkg::tri_out_t triangle;

  lsct_pkg::seg_in_t  seg_queue[$];
  lsct_pkg::tri_out_t tri_expected[$];
  int       errors;
  int       tri_seen;
  int       seg_sent;
  int       cycle_count;
  int       gap_left;
  int       burst_left;

  line_segment_cylinder_tessellator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .segment(segment), .valid(valid), .triangle(triangle)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_mul(longint a, longint b, int sh);
    longint unsigned ma, mb, p;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Taylor-series cosine and sine of ring step k, Q2.30.
  task automatic step_trig(input int k, output longint co, output longint si);
    int t, q, r;
    longint unsigned x, term;
    longint c, s;
    t = 4 * k;
    q = (t / lsct_pkg::RING_STEPS) & 3;
    r = t % lsct_pkg::RING_STEPS;
    x = (64'd1686629713 * r + lsct_pkg::RING_STEPS / 2) / lsct_pkg::RING_STEPS;
    term = 64'd1 << 30;
    c = 0;
    s = 0;
    for (int n = 0; n <= 17; n++) begin
      if ((n & 1) == 0) c += ((n / 2) & 1) ? -longint'(term) : longint'(term);
      else s += (((n - 1) / 2) & 1) ? -longint'(term) : longint'(term);
      term = ((term * x) >> 30) / (n + 1);
    end
    if (c < 0) c = 0;
    if (c > (64'sd1 << 30)) c = 64'sd1 << 30;
    if (s < 0) s = 0;
    if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
    case (q)
      0: begin co = c; si = s; end
      1: begin co = -s; si = c; end
      2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endtask

  function automatic logic [95:0] vertex(longint b[3], longint o[3]);
    logic [95:0] v;
    for (int j = 0; j < 3; j++) v[95 - 32*j -: 32] = 32'(clamp_coord(b[j] + o[j]));
    return v;
  endfunction

  task automatic tessellate_segment(input lsct_pkg::seg_in_t sg);
    longint st[3], en[3], d[3], zero[3], offs[lsct_pkg::RING_STEPS][3];
    longint unsigned a[3], m, len;
    longint nx, nz, w, co, si;
    lsct_pkg::tri_out_t tr;
    int k2;
    st = '{sg.start_x, sg.start_y, sg.start_z};
    en = '{sg.end_x, sg.end_y, sg.end_z};
    zero = '{0, 0, 0};
    nx = 0;
    nz = 0;
    w = sg.line_width;
    for (int j = 0; j < 3; j++) begin
      d[j] = en[j] - st[j];
      a[j] = (d[j] < 0) ? -d[j] : d[j];
    end
    m = (a[0] > a[1]) ? a[0] : a[1];
    if (a[2] > m) m = a[2];
    if (m != 0) begin
      while (m >= (64'd1 << 31)) begin
        m >>= 1;
        for (int j = 0; j < 3; j++) a[j] >>= 1;
      end
      while (m < (64'd1 << 30)) begin
        m <<= 1;
        for (int j = 0; j < 3; j++) a[j] <<= 1;
      end
      len = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      nx = (a[0] << 30) / len;
      nz = (a[2] << 30) / len;
      if (d[0] < 0) nx = -nx;
      if (d[2] < 0) nz = -nz;
    end
    for (int k = 0; k < lsct_pkg::RING_STEPS; k++) begin
      step_trig(k, co, si);
      offs[k][0] = -round_mul(round_mul(nz, si, 30), w, 31);
      offs[k][1] = round_mul(co, w, 31);
      offs[k][2] = round_mul(round_mul(nx, si, 30), w, 31);
    end
    for (int k = 0; k < lsct_pkg::RING_STEPS; k++) begin
      k2 = (k + 1) % lsct_pkg::RING_STEPS;
      tr = {vertex(st, offs[k]), vertex(st, offs[k2]), vertex(en, offs[k]), 1'b0};
      tri_expected = {tri_expected, tr};
      tr = {vertex(st, offs[k2]), vertex(en, offs[k2]), vertex(en, offs[k]), 1'b0};
      tri_expected = {tri_expected, tr};
      tr = {vertex(st, zero), vertex(st, offs[k]), vertex(st, offs[k2]), 1'b0};
      tri_expected = {tri_expected, tr};
      tr = {vertex(en, zero), vertex(en, offs[k2]), vertex(en, offs[k]),
            k == lsct_pkg::RING_STEPS - 1};
      tri_expected = {tri_expected, tr};
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 200000) - 100000;
      default: return $urandom();
    endcase
  endfunction

  function automatic lsct_pkg::seg_in_t make_seg(logic [31:0] sx, logic [31:0] sy,
                                                 logic [31:0] sz, logic [31:0] ex,
                                                 logic [31:0] ey, logic [31:0] ez,
                                                 logic [30:0] wd);
    lsct_pkg::seg_in_t s;
    s = {sx, sy, sz, ex, ey, ez, wd};
    return s;
  endfunction

  // Segment driver: random bursts separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else begin
      if (start) begin
        tessellate_segment(segment);
        seg_sent <= seg_sent + 1;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (seg_queue.size() > 0) begin
        segment <= seg_queue.pop_front();
        start <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 6);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Triangle monitor; the receiver has no back-pressure, so every strobe counts.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && valid) begin
      tri_seen <= tri_seen + 1;
      if (tri_expected.size() == 0) begin
        errors <= errors + 1;
        $display("%0t: unexpected triangle %h", $time, triangle);
      end else begin
        lsct_pkg::tri_out_t e;
        e = tri_expected.pop_front();
        if (e !== triangle) begin
          errors <= errors + 1;
          $display("%0t: triangle mismatch expected %h actual %h", $time, e, triangle);
        end
      end
    end
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] ext[4];
    rst = 1'b1;
    start = 1'b0;
    segment = '0;
    errors = 0;
    tri_seen = 0;
    seg_sent = 0;
    cycle_count = 0;
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    // Directed: zero length, axis-aligned, extreme coordinates and widths.
    seg_queue = {seg_queue, make_seg(0, 0, 0, 0, 0, 0, 31'h10000)};
    seg_queue = {seg_queue, make_seg(5, 6, 7, 5, 6, 7, 31'h7fffffff)};
    seg_queue = {seg_queue, make_seg(0, 0, 0, 32'h10000, 0, 0, 31'h20000)};
    seg_queue = {seg_queue, make_seg(0, 0, 0, 0, 32'h10000, 0, 31'h20000)};
    seg_queue = {seg_queue, make_seg(0, 0, 0, 0, 0, 32'h10000, 31'h20000)};
    seg_queue = {seg_queue, make_seg(0, 0, 0, 32'hffff0000, 0, 32'hffff0000, 31'h20000)};
    seg_queue = {seg_queue, make_seg(0, 0, 0, 1, 0, 0, 31'h0)};
    seg_queue = {seg_queue, make_seg(32'h80000000, 32'h80000000, 32'h80000000,
                                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                     31'h7fffffff)};
    seg_queue = {seg_queue, make_seg(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                     32'h80000000, 32'h80000000, 32'h80000000,
                                     31'h7fffffff)};
    seg_queue = {seg_queue, make_seg(32'h7fff0000, 32'h7fff0000, 0,
                                     32'h7ffff000, 32'h80000000, 32'h1, 31'h40000000)};
    for (int i = 0; i < 8; i++)
      seg_queue = {seg_queue, make_seg(ext[i%4], ext[(i+1)%4], ext[(i+2)%4],
                                       ext[(i+3)%4], ext[i%4], ext[(i+1)%4],
                                       31'($urandom()))};
    for (int i = 0; i < 102; i++) begin
      logic [31:0] sx, sy, sz;
      sx = rand_coord();
      sy = rand_coord();
      sz = rand_coord();
      if ($urandom_range(0, 3) == 0)
        seg_queue = {seg_queue, make_seg(sx, sy, sz, sx + $urandom_range(0, 64),
                                         sy, sz - $urandom_range(0, 64),
                                         31'($urandom()))};
      else
        seg_queue = {seg_queue, make_seg(sx, sy, sz, rand_coord(), rand_coord(),
                                         rand_coord(),
                                         ($urandom_range(0, 1)) ? 31'($urandom())
                                           : 31'($urandom_range(0, 1 << 20)))};
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (seg_queue.size() == 0);
    @(posedge clk);
    while (start) @(posedge clk);
    while (tri_expected.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d segments, checked %0d triangles, %0d errors.",
             seg_sent, tri_seen, errors);
    if (errors == 0 && tri_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
